// ===== rtl/keyframe_position_sampler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Keyframe position sampler assertion macros
// Shared property shapes for the concurrent checks of the sampler modules.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_POSITION_SAMPLER_UNIT_DEFINES_SVH
`define KEYFRAME_POSITION_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define KPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define KPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyframe position sampler package
// Shared types, field widths and codes of the sampler.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int unsigned FrameW = 24;
  localparam int unsigned PosW   = 32;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned DivNumW = 57;
  localparam int unsigned DivCntW = 6;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [1:0] REG_REST_X    = 2'd1;
  localparam logic [1:0] REG_REST_Y    = 2'd2;
  localparam logic [1:0] REG_REST_Z    = 2'd3;

  // Input selector values.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Result case codes.
  localparam logic [1:0] CASE_REST   = 2'd0;
  localparam logic [1:0] CASE_BEFORE = 2'd1;
  localparam logic [1:0] CASE_AFTER  = 2'd2;
  localparam logic [1:0] CASE_INTERP = 2'd3;

  // One stored key.
  typedef struct packed {
    logic signed [PosW-1:0] z;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] x;
    logic [FrameW-1:0]      frame;
  } key_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic              is_sample;
    logic [IndexW-1:0] key_index;
    logic [FrameW-1:0] frame;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] mag;
    logic [FrameW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
    logic               rem_nz;
  } div_rsp_t;

endpackage

// ===== rtl/kps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/kps_front.sv =====
// ----------------------------------------------------------------------------
// Sampler front end
// Accepts input beats, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module kps_front #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic                          func_i,
  input  logic [kps_pkg::IndexW-1:0]    key_index_i,
  input  logic [kps_pkg::FrameW-1:0]    key_frame_i,
  input  logic signed [kps_pkg::PosW-1:0] key_x_i,
  input  logic signed [kps_pkg::PosW-1:0] key_y_i,
  input  logic signed [kps_pkg::PosW-1:0] key_z_i,
  input  logic [kps_pkg::FrameW-1:0]    sample_frame_i,
  output logic                          q_valid_o,
  output kps_pkg::cmd_t                 q_data_o,
  input  logic                          q_pop_i
);
  import kps_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       keep, push;
  cmd_t       cmd;

  // Writes to slots beyond the track are accepted and dropped here.
  assign keep = (func_i == FUNC_SAMPLE) || (32'(key_index_i) < MAX_KEYS);

  always_comb begin
    cmd.is_sample = (func_i == FUNC_SAMPLE);
    cmd.key_index = key_index_i;
    cmd.frame     = (func_i == FUNC_SAMPLE) ? sample_frame_i : key_frame_i;
    cmd.x         = key_x_i;
    cmd.y         = key_y_i;
    cmd.z         = key_z_i;
  end

  assign s_ready_o = (count_q != 2'd2);
  assign push      = s_valid_i && s_ready_o && keep;
  assign q_valid_o = (count_q != 2'd0);
  assign q_data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// ===== rtl/kps_div.sv =====
// ----------------------------------------------------------------------------
// Sampler divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kps_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kps_pkg::div_req_t req_i,
  output kps_pkg::div_rsp_t rsp_o
);
  import kps_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [FrameW-1:0]  rem_q, den_q;
  logic [DivNumW-1:0] quot_q;
  logic [FrameW:0]    shifted, diff;
  logic               fits;

  assign shifted = {rem_q, quot_q[DivNumW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.mag;
      den_q  <= req_i.den;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[FrameW-1:0] : shifted[FrameW-1:0];
      quot_q <= {quot_q[DivNumW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

// ===== rtl/kps_back.sv =====
// ----------------------------------------------------------------------------
// Sampler back end
// Executes queued commands: key writes, track search and interpolation.
// ----------------------------------------------------------------------------
`include "keyframe_position_sampler_unit_defines.svh"

module kps_back #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  kps_pkg::cmd_t                    q_data_i,
  output logic                             q_pop_o,
  input  logic [kps_pkg::CountW-1:0]       key_count_i,
  input  logic signed [kps_pkg::PosW-1:0]  rest_x_i,
  input  logic signed [kps_pkg::PosW-1:0]  rest_y_i,
  input  logic signed [kps_pkg::PosW-1:0]  rest_z_i,
  output logic                             ram_we_o,
  output logic [$clog2(MAX_KEYS)-1:0]      ram_waddr_o,
  output kps_pkg::key_t                    ram_wdata_o,
  output logic [$clog2(MAX_KEYS)-1:0]      ram_raddr_o,
  input  kps_pkg::key_t                    ram_rdata_i,
  output kps_pkg::div_req_t                div_req_o,
  input  kps_pkg::div_rsp_t                div_rsp_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [kps_pkg::PosW-1:0]  out_x_o,
  output logic signed [kps_pkg::PosW-1:0]  out_y_o,
  output logic signed [kps_pkg::PosW-1:0]  out_z_o,
  output logic [1:0]                       case_code_o
);
  import kps_pkg::*;

  localparam int unsigned AW = $clog2(MAX_KEYS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIRST = 8'b0000_0010,
    S_LAST  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIVST = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW:0]             n_keys;
  logic [AW-1:0]           nlast_q, idx_q, raddr;
  logic [FrameW-1:0]       f_q, num_q, den_q;
  key_t                    prev_q, cur_q;
  logic [1:0]              comp_q;
  logic signed [PosW-1:0]  res_q [3];
  logic [1:0]              code_q;
  logic signed [PosW-1:0]  v0, v1, v0_q;
  logic signed [PosW:0]    diff;
  logic signed [DivNumW:0] prod_q;
  logic [PosW-1:0]         q32;
  logic                    out_valid_q, load_out;
  logic signed [PosW-1:0]  out_x_q, out_y_q, out_z_q;
  logic [1:0]              out_code_q;

  // Effective key count, clipped to the track size.
  assign n_keys = (32'(key_count_i) > MAX_KEYS) ? (AW+1)'(MAX_KEYS) : (AW+1)'(key_count_i);

  always_comb begin
    unique case (comp_q)
      2'd0:    begin v0 = prev_q.x; v1 = cur_q.x; end
      2'd1:    begin v0 = prev_q.y; v1 = cur_q.y; end
      default: begin v0 = prev_q.z; v1 = cur_q.z; end
    endcase
  end

  assign diff = {v1[PosW-1], v1} - {v0[PosW-1], v0};
  // Floor of a negative quotient: negate magnitude, step down on remainder.
  assign q32  = prod_q[DivNumW] ?
                (PosW'(0) - div_rsp_i.quot[PosW-1:0] - PosW'(div_rsp_i.rem_nz)) :
                div_rsp_i.quot[PosW-1:0];

  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    ram_we_o = 1'b0;
    raddr = idx_q;
    unique case (state_q)
      S_IDLE: begin
        raddr = '0;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (!q_data_i.is_sample) begin
            ram_we_o = 1'b1;
          end else if (n_keys == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        raddr = nlast_q;
        state_d = (f_q <= ram_rdata_i.frame) ? S_OUT : S_LAST;
      end
      S_LAST: begin
        raddr = AW'(1);
        state_d = (f_q >= ram_rdata_i.frame) ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        raddr = idx_q + 1'b1;
        if (f_q < ram_rdata_i.frame) begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_DIVST;
      S_DIVST: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp_i.done) begin
          state_d = (comp_q == 2'd2) ? S_OUT : S_MUL;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_raddr_o = raddr;
  assign ram_waddr_o = AW'(q_data_i.key_index);
  always_comb begin
    ram_wdata_o.frame = q_data_i.frame;
    ram_wdata_o.x     = q_data_i.x;
    ram_wdata_o.y     = q_data_i.y;
    ram_wdata_o.z     = q_data_i.z;
  end

  assign div_req_o.start = (state_q == S_DIVST);
  assign div_req_o.mag   = prod_q[DivNumW] ? DivNumW'(-prod_q) : DivNumW'(prod_q);
  assign div_req_o.den   = den_q;

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        f_q     <= q_data_i.frame;
        nlast_q <= AW'(n_keys - 1'b1);
        res_q[0] <= rest_x_i;
        res_q[1] <= rest_y_i;
        res_q[2] <= rest_z_i;
        code_q  <= CASE_REST;
      end
      S_FIRST: begin
        prev_q  <= ram_rdata_i;
        res_q[0] <= ram_rdata_i.x;
        res_q[1] <= ram_rdata_i.y;
        res_q[2] <= ram_rdata_i.z;
        code_q  <= CASE_BEFORE;
      end
      S_LAST: begin
        idx_q   <= AW'(1);
        res_q[0] <= ram_rdata_i.x;
        res_q[1] <= ram_rdata_i.y;
        res_q[2] <= ram_rdata_i.z;
        code_q  <= CASE_AFTER;
      end
      S_SCAN: begin
        if (f_q < ram_rdata_i.frame) begin
          cur_q  <= ram_rdata_i;
          num_q  <= f_q - prev_q.frame;
          den_q  <= ram_rdata_i.frame - prev_q.frame;
          comp_q <= 2'd0;
          code_q <= CASE_INTERP;
        end else begin
          prev_q <= ram_rdata_i;
          idx_q  <= idx_q + 1'b1;
        end
      end
      S_MUL: begin
        v0_q   <= v0;
        prod_q <= diff * $signed({1'b0, num_q});
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          res_q[comp_q] <= v0_q + $signed(q32);
          comp_q <= comp_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q    <= res_q[0];
      out_y_q    <= res_q[1];
      out_z_q    <= res_q[2];
      out_code_q <= code_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign case_code_o = out_code_q;

  `KPS_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_OUT, "result loaded outside the output step")
  `KPS_ASSERT_IMPL(a_scan_in_track, state_q == S_SCAN, idx_q <= nlast_q, "key scan ran past the last key")
  `KPS_ASSERT_IMPL(a_div_done_wait, div_rsp_i.done, state_q == S_DIV, "divider finished while nobody waited")
  `KPS_ASSERT_NEXT(a_div_start_wait, state_q == S_DIVST, state_q == S_DIV, "division start not followed by wait")

endmodule

// ===== rtl/keyframe_position_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// Keyframe position sampler
// Position key track with clamped linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// The input stream carries two kinds of beat, chosen by s_axis_tuser: a key
// write stores a frame number and an XYZ position in a slot of the track and
// gives no output beat; a sample beat gives one output beat with the XYZ
// position at the requested frame and a case code in m_axis_tuser.
// Configuration (key count and rest position) is written through the plain
// write port, only while the block is idle: a rule for the user, not enforced.
// A front end accepts and classifies beats into a two-entry command queue; a
// back end drains it. A key write reaches the key memory at the edge at which
// it leaves the queue. A sample reads keys one per cycle from the single read
// port of the key memory. From leaving the queue, the rest case goes straight
// to the output step; a sample clamped to the first key reads the first key
// first, and one clamped to the last key reads the first and then the last
// key. An interpolation reads the first and last keys, scans the keys in order,
// then for each of the three components takes a multiply step, a start step
// and a 57-step bit-serial divide, and ends with the output step.
// The result sits in an output register; while the receiver stalls, the back
// end may finish the next sample and wait, and the queue accepts until full.
// Reset clears the control state and the configuration registers; key
// memory contents are undefined until written.
// ----------------------------------------------------------------------------
module keyframe_position_sampler_unit #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: key_index[5:0], key_frame[29:6], key_x[61:30], key_y[93:62],
  //        key_z[125:94], sample_frame[149:126], zero pad[151:150]
  input  logic [151:0] s_axis_tdata,
  // tuser: func[0]
  input  logic         s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  m_axis_tdata,
  // tuser: case_code[1:0]
  output logic [1:0]   m_axis_tuser,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);
  import kps_pkg::*;

  localparam int unsigned AW = $clog2(MAX_KEYS);

  logic [CountW-1:0]      key_count_q;
  logic signed [PosW-1:0] rest_x_q, rest_y_q, rest_z_q;

  logic    q_valid, q_pop;
  cmd_t    q_data;
  logic    ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  key_t    ram_wdata, ram_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic signed [PosW-1:0] out_x, out_y, out_z;

  // Configuration registers; the key count keeps its low seven bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      rest_x_q    <= '0;
      rest_y_q    <= '0;
      rest_z_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_KEY_COUNT: key_count_q <= cfg_wdata_i[CountW-1:0];
        REG_REST_X:    rest_x_q    <= cfg_wdata_i;
        REG_REST_Y:    rest_y_q    <= cfg_wdata_i;
        REG_REST_Z:    rest_z_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  kps_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .func_i         (s_axis_tuser),
    .key_index_i    (s_axis_tdata[5:0]),
    .key_frame_i    (s_axis_tdata[29:6]),
    .key_x_i        (s_axis_tdata[61:30]),
    .key_y_i        (s_axis_tdata[93:62]),
    .key_z_i        (s_axis_tdata[125:94]),
    .sample_frame_i (s_axis_tdata[149:126]),
    .q_valid_o      (q_valid),
    .q_data_o       (q_data),
    .q_pop_i        (q_pop)
  );

  // Key track memory: one entry per slot, frame and position together.
  kps_ram #(.WIDTH($bits(key_t)), .DEPTH(MAX_KEYS)) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  kps_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .key_count_i (key_count_q),
    .rest_x_i    (rest_x_q),
    .rest_y_i    (rest_y_q),
    .rest_z_i    (rest_z_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .case_code_o (m_axis_tuser)
  );

  assign m_axis_tdata = {out_z, out_y, out_x};

endmodule
